[design/bmhq_pkg.sv]
// shared types and constants for the binary min-heap queue
// used by bmhq_cmp and binary_min_heap_queue; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = CNT_W + 1;
    localparam int ENTRY_W  = 64;
    localparam int TOTAL_W  = 11;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_PEEK   = 2'd2
    } kind_e;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_LAST,
        S_UP_CHK,
        S_UP_WAIT,
        S_DN_CHK,
        S_DN_WAIT,
        S_DN_CMP2,
        S_DONE
    } state_e;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] key;
        logic [15:0] value_first;
        logic [15:0] value_second;
    } in_item_t;

    typedef struct packed {
        logic [31:0]        out_key;
        logic [15:0]        out_value_first;
        logic [15:0]        out_value_second;
        logic [1:0]         status;
        logic [TOTAL_W-1:0] entry_total;
    } out_item_t;

endpackage

`default_nettype wire

[design/bmhq_ram.sv]
// generic simple dual-port memory: one write port, two registered read ports
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bmhq_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr_a,
    input  wire logic [ADDR_W-1:0] raddr_b,
    output logic      [DATA_W-1:0] rdata_a,
    output logic      [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

[design/bmhq_cmp.sv]
// shared entry comparator: unsigned less-than over packed heap entries
// depends on bmhq_pkg
`timescale 1ns / 1ps
`default_nettype none

module bmhq_cmp (
    input  wire logic [bmhq_pkg::ENTRY_W-1:0] a,
    input  wire logic [bmhq_pkg::ENTRY_W-1:0] b,
    output logic                              lt
);

    // key, then first value, then second value: plain unsigned order of the word
    assign lt = (a < b);

endmodule

`default_nettype wire

[design/binary_min_heap_queue.sv]
// binary min-heap queue: sequencer, heap memory and shared comparator
// depends on bmhq_pkg, bmhq_ram, bmhq_cmp
//
// usage:
//   req channel (req_valid / req_stall / req) carries one operation: insert,
//   remove minimum or peek minimum (an unused kind code acts as peek).
//   rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one result per
//   request: the minimum entry (the removed entry for remove), status and count.
//   one request is worked on at a time; req_stall is high while it runs.
//   operation time depends on the kind: peek, full insert, empty remove and
//   remove of the last entry go straight to the done state; insert climbs
//   toward the root with a check and a wait state per level until it settles;
//   remove reads the last entry, then descends with a check, a wait and a second
//   compare state per level. the time is set by the single comparator and the
//   registered read of the heap memory at each level. the result shows up in
//   the same cycle that the next request can be taken; while an earlier result
//   waits under rsp_stall, a finished result waits in the done state until the
//   earlier one is taken.
//   reset empties the queue at once (count to zero); no clearing pass is run,
//   only data read from slots already written is used.
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire bmhq_pkg::in_item_t  req,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output bmhq_pkg::out_item_t      rsp
);

    localparam int ADDR_W  = bmhq_pkg::ADDR_W;
    localparam int CNT_W   = bmhq_pkg::CNT_W;
    localparam int IDX_W   = bmhq_pkg::IDX_W;
    localparam int ENTRY_W = bmhq_pkg::ENTRY_W;
    localparam int TOTAL_W = bmhq_pkg::TOTAL_W;

    bmhq_pkg::state_e state_reg, state_next;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic [ENTRY_W-1:0] e_reg, e_next;
    logic [ENTRY_W-1:0] root_reg;
    logic [ENTRY_W-1:0] res_reg, res_next;
    logic [ENTRY_W-1:0] best_val_reg, best_val_next;
    logic               best_left_reg, best_left_next;
    logic [1:0]         status_reg, status_next;
    logic               use_root_reg, use_root_next;
    logic               out_valid_reg, out_valid_next;
    bmhq_pkg::out_item_t out_data_reg, out_data_next;

    logic               req_xfer;
    logic               rsp_xfer;
    logic               can_load;
    logic               full;
    logic               empty;
    logic [ENTRY_W-1:0] req_entry;

    logic [CNT_W-1:0]   parent_slot;
    logic [IDX_W-1:0]   left_slot;
    logic [IDX_W-1:0]   right_slot;
    logic [IDX_W-1:0]   count_ext;
    logic               left_in;
    logic               right_in;
    logic               take_right;
    logic               moved;
    logic [ENTRY_W-1:0] move_val;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr_a;
    logic [ADDR_W-1:0]  ram_raddr_b;
    logic [ENTRY_W-1:0] ram_rdata_a;
    logic [ENTRY_W-1:0] ram_rdata_b;

    logic [ENTRY_W-1:0] cmp_a;
    logic [ENTRY_W-1:0] cmp_b;
    logic               cmp_lt;

    bmhq_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (bmhq_pkg::CAPACITY)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    bmhq_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .lt (cmp_lt)
    );

    assign req_stall = (state_reg != bmhq_pkg::S_IDLE);
    assign req_xfer  = req_valid && !req_stall;
    assign rsp_xfer  = out_valid_reg && !rsp_stall;
    assign can_load  = !out_valid_reg || !rsp_stall;
    assign full      = (count_reg == CNT_W'(bmhq_pkg::CAPACITY));
    assign empty     = (count_reg == '0);
    assign req_entry = {req.key, req.value_first, req.value_second};

    // heap slots are 1-based; memory address is slot - 1
    assign parent_slot = pos_reg >> 1;
    assign left_slot   = {pos_reg, 1'b0};
    assign right_slot  = left_slot + IDX_W'(1);
    assign count_ext   = {1'b0, count_reg};
    assign left_in     = (left_slot <= count_ext);
    assign right_in    = (right_slot <= count_ext);

    assign take_right  = right_in && cmp_lt;
    assign moved       = take_right || best_left_reg;
    assign move_val    = take_right ? ram_rdata_b : best_val_reg;

    // shared comparator operand selection
    always_comb
    begin
        case (state_reg)
            bmhq_pkg::S_UP_WAIT:
            begin
                cmp_a = e_reg;
                cmp_b = ram_rdata_a;
            end
            bmhq_pkg::S_DN_WAIT:
            begin
                cmp_a = ram_rdata_a;
                cmp_b = e_reg;
            end
            bmhq_pkg::S_DN_CMP2:
            begin
                cmp_a = ram_rdata_b;
                cmp_b = best_val_reg;
            end
            default:
            begin
                cmp_a = e_reg;
                cmp_b = ram_rdata_a;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bmhq_pkg::S_IDLE:
            begin
                if (req_xfer)
                begin
                    case (req.kind)
                        bmhq_pkg::KIND_INSERT:
                        begin
                            state_next = full ? bmhq_pkg::S_DONE : bmhq_pkg::S_UP_CHK;
                        end
                        bmhq_pkg::KIND_REMOVE:
                        begin
                            if (empty || count_reg == CNT_W'(1))
                            begin
                                state_next = bmhq_pkg::S_DONE;
                            end
                            else
                            begin
                                state_next = bmhq_pkg::S_RD_LAST;
                            end
                        end
                        default:
                        begin
                            state_next = bmhq_pkg::S_DONE;
                        end
                    endcase
                end
            end
            bmhq_pkg::S_RD_LAST:
            begin
                state_next = bmhq_pkg::S_DN_CHK;
            end
            bmhq_pkg::S_UP_CHK:
            begin
                if (pos_reg == CNT_W'(1))
                begin
                    state_next = bmhq_pkg::S_DONE;
                end
                else
                begin
                    state_next = bmhq_pkg::S_UP_WAIT;
                end
            end
            bmhq_pkg::S_UP_WAIT:
            begin
                state_next = cmp_lt ? bmhq_pkg::S_UP_CHK : bmhq_pkg::S_DONE;
            end
            bmhq_pkg::S_DN_CHK:
            begin
                state_next = left_in ? bmhq_pkg::S_DN_WAIT : bmhq_pkg::S_DONE;
            end
            bmhq_pkg::S_DN_WAIT:
            begin
                state_next = bmhq_pkg::S_DN_CMP2;
            end
            bmhq_pkg::S_DN_CMP2:
            begin
                state_next = moved ? bmhq_pkg::S_DN_CHK : bmhq_pkg::S_DONE;
            end
            bmhq_pkg::S_DONE:
            begin
                if (can_load)
                begin
                    state_next = bmhq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bmhq_pkg::S_IDLE;
            end
        endcase
    end

    // memory port control
    always_comb
    begin
        ram_we      = 1'b0;
        ram_waddr   = ADDR_W'(pos_reg - CNT_W'(1));
        ram_wdata   = e_reg;
        ram_re      = 1'b0;
        ram_raddr_a = ADDR_W'(left_slot - IDX_W'(1));
        ram_raddr_b = ADDR_W'(left_slot);
        case (state_reg)
            bmhq_pkg::S_IDLE:
            begin
                // fetch the last entry for a remove
                ram_re      = req_xfer && (req.kind == bmhq_pkg::KIND_REMOVE) && !empty;
                ram_raddr_a = ADDR_W'(count_reg - CNT_W'(1));
            end
            bmhq_pkg::S_UP_CHK:
            begin
                if (pos_reg == CNT_W'(1))
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    ram_re      = 1'b1;
                    ram_raddr_a = ADDR_W'(parent_slot - CNT_W'(1));
                end
            end
            bmhq_pkg::S_UP_WAIT:
            begin
                // parent moves down into the hole, or the new entry settles here
                ram_we    = 1'b1;
                ram_wdata = cmp_lt ? ram_rdata_a : e_reg;
            end
            bmhq_pkg::S_DN_CHK:
            begin
                if (left_in)
                begin
                    ram_re = 1'b1;
                end
                else
                begin
                    ram_we = 1'b1;
                end
            end
            bmhq_pkg::S_DN_CMP2:
            begin
                ram_we    = 1'b1;
                ram_wdata = moved ? move_val : e_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        count_next     = count_reg;
        pos_next       = pos_reg;
        e_next         = e_reg;
        res_next       = res_reg;
        best_val_next  = best_val_reg;
        best_left_next = best_left_reg;
        status_next    = status_reg;
        use_root_next  = use_root_reg;
        case (state_reg)
            bmhq_pkg::S_IDLE:
            begin
                if (req_xfer)
                begin
                    status_next   = bmhq_pkg::ST_OK;
                    use_root_next = 1'b1;
                    case (req.kind)
                        bmhq_pkg::KIND_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = bmhq_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                                pos_next   = count_reg + CNT_W'(1);
                                e_next     = req_entry;
                            end
                        end
                        bmhq_pkg::KIND_REMOVE:
                        begin
                            if (empty)
                            begin
                                status_next = bmhq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next    = count_reg - CNT_W'(1);
                                pos_next      = CNT_W'(1);
                                res_next      = root_reg;
                                use_root_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            if (empty)
                            begin
                                status_next = bmhq_pkg::ST_EMPTY;
                            end
                        end
                    endcase
                end
            end
            bmhq_pkg::S_RD_LAST:
            begin
                e_next = ram_rdata_a;
            end
            bmhq_pkg::S_UP_WAIT:
            begin
                if (cmp_lt)
                begin
                    pos_next = parent_slot;
                end
            end
            bmhq_pkg::S_DN_WAIT:
            begin
                best_val_next  = cmp_lt ? ram_rdata_a : e_reg;
                best_left_next = cmp_lt;
            end
            bmhq_pkg::S_DN_CMP2:
            begin
                if (moved)
                begin
                    pos_next = take_right ? CNT_W'(right_slot) : CNT_W'(left_slot);
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (rsp_xfer)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == bmhq_pkg::S_DONE && can_load)
        begin
            out_valid_next = 1'b1;
            if (status_reg == bmhq_pkg::ST_EMPTY)
            begin
                {out_data_next.out_key, out_data_next.out_value_first,
                 out_data_next.out_value_second} = '0;
            end
            else if (use_root_reg)
            begin
                {out_data_next.out_key, out_data_next.out_value_first,
                 out_data_next.out_value_second} = root_reg;
            end
            else
            begin
                {out_data_next.out_key, out_data_next.out_value_first,
                 out_data_next.out_value_second} = res_reg;
            end
            out_data_next.status      = status_reg;
            out_data_next.entry_total = TOTAL_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bmhq_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        e_reg         <= e_next;
        res_reg       <= res_next;
        best_val_reg  <= best_val_next;
        best_left_reg <= best_left_next;
        status_reg    <= status_next;
        use_root_reg  <= use_root_next;
        out_data_reg  <= out_data_next;
        // cached copy of slot one
        if (ram_we && ram_waddr == '0)
        begin
            root_reg <= ram_wdata;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(bmhq_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ({1'b0, ram_waddr} < count_reg))
        else $error("heap write outside occupied slots");

    a_full_total: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == bmhq_pkg::ST_FULL)
        |-> (rsp.entry_total == TOTAL_W'(bmhq_pkg::CAPACITY)))
        else $error("full status with count below capacity");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == bmhq_pkg::ST_EMPTY)
        |-> (rsp.entry_total == '0 && rsp.out_key == '0))
        else $error("empty status with nonzero result");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bmhq_pkg::S_DONE && can_load) |=> rsp_valid)
        else $error("finished operation did not load a result");

endmodule

`default_nettype wire
